// ===== hw/rtl/mawds_pkg.sv =====
// Shared types, register codes and helpers of the mip level downsampler.
`timescale 1ns / 1ps
`default_nettype none
package mawds_pkg;

	localparam int unsigned CFG_W = 11;
	localparam int unsigned MAX_WIDTH_DEF = 1024;

	typedef enum logic [1:0] {
		REG_SOURCE_WIDTH   = 2'd0,
		REG_SOURCE_HEIGHT  = 2'd1,
		REG_ALPHA_WEIGHTED = 2'd2
	} cfg_reg_t;

	// sums over a horizontal pair: 87 bits, one line store entry
	typedef struct packed {
		logic [3:0][8:0]  sum;
		logic [2:0][16:0] wsum;
	} pair_sums_t;

	// sums over a full block
	typedef struct packed {
		logic [3:0][9:0]  sum;
		logic [2:0][17:0] wsum;
	} block_sums_t;

	typedef logic [2:0][18:0] dividend_t;
	typedef logic [2:0][7:0]  quot_t;

	function automatic logic [CFG_W-1:0] pow2_floor(input logic [CFG_W-1:0] v);
		logic [CFG_W-1:0] r;
		r = CFG_W'(1);
		for (int i = 0; i < CFG_W; i++) begin
			if (v[i]) begin
				r = CFG_W'(1) << i;
			end
		end
		return r;
	endfunction

	function automatic block_sums_t widen(input pair_sums_t p);
		block_sums_t b;
		for (int c = 0; c < 4; c++) begin
			b.sum[c] = {1'b0, p.sum[c]};
		end
		for (int c = 0; c < 3; c++) begin
			b.wsum[c] = {1'b0, p.wsum[c]};
		end
		return b;
	endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/mawds_ram.sv =====
// Generic single-port-write, registered-read RAM.
`timescale 1ns / 1ps
`default_nettype none
module mawds_ram #(
	parameter int unsigned WIDTH = 87,
	parameter int unsigned DEPTH = 512,
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [AW-1:0]            waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [AW-1:0]            raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule
`default_nettype wire

// ===== hw/rtl/mawds_div.sv =====
// Three-lane restoring divider, two quotient bits per cycle, shared divisor.
`timescale 1ns / 1ps
`default_nettype none
module mawds_div (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                start,
	input  wire mawds_pkg::dividend_t dividend,
	input  wire logic [9:0]          divisor,
	output logic                     done,
	output mawds_pkg::quot_t         quot
);
	import mawds_pkg::*;

	dividend_t rem_q, rem_nxt;
	quot_t     quo_q, quo_nxt;
	logic [9:0] div_q;
	logic [1:0] step_q;
	logic       run_q;

	always_comb begin
		logic [18:0] r;
		logic [18:0] d;
		logic [2:0]  b;
		rem_nxt = rem_q;
		quo_nxt = quo_q;
		for (int ch = 0; ch < 3; ch++) begin
			r = rem_q[ch];
			for (int j = 0; j < 2; j++) begin
				b = {step_q, (j == 0) ? 1'b1 : 1'b0};
				d = 19'(div_q) << b;
				if (r >= d) begin
					r = r - d;
					quo_nxt[ch][b] = 1'b1;
				end
			end
			rem_nxt[ch] = r;
		end
	end

	assign done = run_q && (step_q == 2'd0);
	assign quot = quo_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			step_q <= 2'd0;
		end else if (start) begin
			run_q  <= 1'b1;
			step_q <= 2'd3;
		end else if (run_q) begin
			step_q <= step_q - 2'd1;
			if (step_q == 2'd0) begin
				run_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= dividend;
			quo_q <= '0;
			div_q <= divisor;
		end else if (run_q) begin
			rem_q <= rem_nxt;
			quo_q <= quo_nxt;
		end
	end
endmodule
`default_nettype wire

// ===== hw/rtl/mipmap_alpha_weighted_downsample_unit.sv =====
// Top level of the 2x2 mip level downsampler with alpha weighting.
`timescale 1ns / 1ps
`default_nettype none
// Takes RGBA source pixels in raster order and emits the next mip level, one
// pixel per completed 2x2 block (2x1, 1x2 or 1x1 for levels with a side of 1).
// Horizontal pair sums of the first row of a block park in a line store of
// MAX_WIDTH/2 entries; the second row reads them back. A pixel closing no block
// leaves the unit ready; one closing a block passes accept, line store read,
// divider steps (two quotient bits per cycle for alpha-weighted colours) and
// output register load, which waits for that register to be free, before the
// next pixel. The output register holds a result while new pixels are taken.
// Any register write restarts the level at its first pixel.
module mipmap_alpha_weighted_downsample_unit #(
	parameter int unsigned MAX_WIDTH = mawds_pkg::MAX_WIDTH_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [7:0] in_red,
	input  wire logic [7:0] in_green,
	input  wire logic [7:0] in_blue,
	input  wire logic [7:0] in_alpha,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic      [7:0] out_red,
	output logic      [7:0] out_green,
	output logic      [7:0] out_blue,
	output logic      [7:0] out_alpha,
	output logic            level_done,
	input  wire logic       cfg_we,
	input  wire logic [1:0] cfg_idx,
	input  wire logic [mawds_pkg::CFG_W-1:0] cfg_wdata
);
	import mawds_pkg::*;

	localparam int unsigned DEPTH = MAX_WIDTH / 2;
	localparam int unsigned CW    = $clog2(MAX_WIDTH);
	localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_RD   = 4'b0010,
		S_DIV  = 4'b0100,
		S_PUSH = 4'b1000
	} state_t;

	state_t           state_q;
	logic [CFG_W-1:0] src_width_q, src_height_q;
	logic             alpha_wt_q;
	logic [CW-1:0]    col_q;
	logic [9:0]       row_q;
	pair_sums_t       acc_q, acc_nxt, pair_s1, rdata;
	logic             done_s1;
	block_sums_t      tot_s2, tot;
	quot_t            q_s3, div_quot;
	dividend_t        dividend;
	logic             div_done;

	logic [CFG_W-1:0] w_clamp, w_pow, h_pow;
	logic             bw2, bh2, last_col, last_row, blk_end, row2, accept;
	logic             mem_we, mem_re;
	logic [1:0]       lc;
	logic [10:0]      half;
	logic [AW-1:0]    line_addr;

	assign w_clamp  = (32'(src_width_q) > MAX_WIDTH) ? CFG_W'(MAX_WIDTH) : src_width_q;
	assign w_pow    = pow2_floor(w_clamp);
	assign h_pow    = pow2_floor(src_height_q);
	assign bw2      = w_pow > CFG_W'(1);
	assign bh2      = h_pow > CFG_W'(1);
	assign last_col = 32'(col_q) == 32'(w_pow) - 32'd1;
	assign last_row = 32'(row_q) == 32'(h_pow) - 32'd1;
	assign blk_end  = !bw2 || col_q[0];
	assign row2     = !bh2 || row_q[0];
	assign in_ready = state_q == S_IDLE;
	assign accept   = in_valid && in_ready;
	assign mem_we   = accept && blk_end && !row2;
	assign mem_re   = accept && blk_end && row2 && bh2;
	assign line_addr = AW'(col_q >> 1);

	always_comb begin
		logic [7:0] px [4];
		px[0] = in_red;
		px[1] = in_green;
		px[2] = in_blue;
		px[3] = in_alpha;
		for (int c = 0; c < 4; c++) begin
			acc_nxt.sum[c] = acc_q.sum[c] + 9'(px[c]);
		end
		for (int c = 0; c < 3; c++) begin
			acc_nxt.wsum[c] = acc_q.wsum[c] + 17'(16'(px[c]) * 16'(px[3]));
		end
	end

	mawds_ram #(.WIDTH($bits(pair_sums_t)), .DEPTH(DEPTH)) u_line (
		.clk   (clk),
		.we    (mem_we),
		.waddr (line_addr),
		.wdata (acc_nxt),
		.re    (mem_re),
		.raddr (line_addr),
		.rdata (rdata)
	);

	// add the parked first-row pair when the block has two rows
	always_comb begin
		block_sums_t a, b;
		a = widen(pair_s1);
		b = bh2 ? widen(rdata) : '0;
		for (int c = 0; c < 4; c++) begin
			tot.sum[c] = a.sum[c] + b.sum[c];
		end
		for (int c = 0; c < 3; c++) begin
			tot.wsum[c] = a.wsum[c] + b.wsum[c];
			dividend[c] = {1'b0, tot.wsum[c]} + 19'(tot.sum[3][9:1]);
		end
	end

	mawds_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (state_q == S_RD),
		.dividend (dividend),
		.divisor  (tot.sum[3]),
		.done     (div_done),
		.quot     (div_quot)
	);

	assign lc   = {1'b0, bw2} + {1'b0, bh2};
	assign half = (lc == 2'd0) ? 11'd0 : (11'd1 << (lc - 2'd1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			src_width_q  <= CFG_W'(1024);
			src_height_q <= CFG_W'(1024);
			alpha_wt_q   <= 1'b1;
			col_q        <= '0;
			row_q        <= '0;
			acc_q        <= '0;
			out_valid    <= 1'b0;
		end else begin
			if (state_q == S_PUSH && (!out_valid || out_ready)) begin
				out_valid <= 1'b1;
			end else if (out_valid && out_ready) begin
				out_valid <= 1'b0;
			end
			if (cfg_we && (cfg_idx == REG_SOURCE_WIDTH || cfg_idx == REG_SOURCE_HEIGHT
					|| cfg_idx == REG_ALPHA_WEIGHTED)) begin
				unique case (cfg_idx)
					REG_SOURCE_WIDTH:  src_width_q  <= cfg_wdata;
					REG_SOURCE_HEIGHT: src_height_q <= cfg_wdata;
					default:           alpha_wt_q   <= cfg_wdata[0];
				endcase
				// restart the level
				col_q <= '0;
				row_q <= '0;
				acc_q <= '0;
			end else if (accept) begin
				acc_q <= blk_end ? '0 : acc_nxt;
				if (blk_end && row2) begin
					state_q <= S_RD;
				end
				if (last_col) begin
					col_q <= '0;
					row_q <= last_row ? 10'd0 : row_q + 10'd1;
				end else begin
					col_q <= col_q + CW'(1);
				end
			end
			unique case (state_q)
				S_IDLE: ;
				S_RD:   state_q <= S_DIV;
				S_DIV: begin
					if (div_done) begin
						state_q <= S_PUSH;
					end
				end
				S_PUSH: begin
					if (!out_valid || out_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		logic [10:0] plain [4];
		logic        use_w;
		if (accept) begin
			pair_s1 <= acc_nxt;
			done_s1 <= last_col && last_row;
		end
		if (state_q == S_RD) begin
			tot_s2 <= tot;
		end
		if (state_q == S_DIV && div_done) begin
			q_s3 <= div_quot;
		end
		for (int c = 0; c < 4; c++) begin
			plain[c] = ({1'b0, tot_s2.sum[c]} + half) >> lc;
		end
		use_w = alpha_wt_q && (tot_s2.sum[3] != 10'd0);
		if (state_q == S_PUSH && (!out_valid || out_ready)) begin
			out_red    <= use_w ? q_s3[0] : plain[0][7:0];
			out_green  <= use_w ? q_s3[1] : plain[1][7:0];
			out_blue   <= use_w ? q_s3[2] : plain[2][7:0];
			out_alpha  <= plain[3][7:0];
			level_done <= done_s1;
		end
	end

	a_div_only_waited: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == S_DIV)
		else $error("divider finished outside its wait");

	a_rd_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_RD |-> $past(in_valid && in_ready))
		else $error("line store read without a closing pixel");

	a_push_fills: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_PUSH && !out_valid) |=> out_valid)
		else $error("free output register not loaded");

	a_col_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		32'(col_q) < 32'(w_pow))
		else $error("column position beyond level width");

endmodule
`default_nettype wire
